// ===== hw/rtl/sha1md_pkg.sv =====
// sha1md_pkg: shared types, constants and round functions of the sha-1 digest unit
// used by sha1md_cell, sha1md_round and sha1_message_digest_unit; no dependencies
package sha1md_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;

    typedef logic [31:0] t_word;
    typedef logic [DIGEST_WORDS-1:0][31:0] t_chain;

    // input request: one message byte plus markers
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_req;

    // output request: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_req;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic init;   // return chaining value to initial values
        logic load;   // copy chaining value into working variables
        logic step;   // run one round
        logic fold;   // add working variables into chaining value
    } t_rnd_ctl;

    localparam t_chain INIT_CHAIN = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                     32'hefcdab89, 32'h67452301};

    localparam t_word K0 = 32'h5a827999;
    localparam t_word K1 = 32'h6ed9eba1;
    localparam t_word K2 = 32'h8f1bbcdc;
    localparam t_word K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round constant by round number
    function automatic t_word round_k(input logic [6:0] t);
        t_word k;
        if (t < 7'd20) begin
            k = K0;
        end else if (t < 7'd40) begin
            k = K1;
        end else if (t < 7'd60) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

    // ch, parity, maj, parity by round number
    function automatic t_word round_f(input logic [6:0] t, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        if (t < 7'd20) begin
            f = (b & c) ^ (~b & d);
        end else if (t < 7'd40) begin
            f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f = (b & c) ^ (b & d) ^ (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ===== hw/rtl/sha1_message_digest_unit.sv =====
// sha1_message_digest_unit: streaming sha-1 hasher, top level and sequencer
// depends on sha1md_pkg, sha1md_cell, sha1md_round

// Takes one message byte per request and returns the 20-byte SHA-1 digest as five
// 32-bit words, most significant first, after the end-of-message request. Bytes are
// taken only while idle; the 64th byte of a block starts 80 rounds through the single
// round unit, then a fold into the chaining value. The end of a message runs a setup
// step, 16 - n word pushes of padding (n = whole words already in the block), a
// compression, and when fewer than 9 bytes of room remain a second block of 16 pushes
// and a compression, then five output words, each held while the output stalls. The
// schedule is a chain of sixteen word cells that shifts once per round.
// After the last digest word is taken the unit is ready for a new message.
module sha1_message_digest_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sha1md_pkg::t_in_req  i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sha1md_pkg::t_out_req o_out_req
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_ADD,
        S_PSET,
        S_PAD,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [60:0]        r_cnt;
    logic [23:0]        r_acc;
    logic [6:0]         r_t;
    logic [3:0]         r_wi;
    logic [2:0]         r_oidx;
    logic               r_fin;
    logic               r_first;
    logic               r_len_here;
    logic               r_len_sent;
    logic               r_pad_started;

    sha1md_pkg::t_word  w_cell [sha1md_pkg::BLOCK_WORDS];
    sha1md_pkg::t_word  tail_in;
    sha1md_pkg::t_word  sched_new;
    sha1md_pkg::t_word  byte_word;
    sha1md_pkg::t_word  pad_word;
    sha1md_pkg::t_word  first_word;
    sha1md_pkg::t_word  xor_w;
    sha1md_pkg::t_chain h;
    sha1md_pkg::t_rnd_ctl ctl;
    logic [5:0]         pos;
    logic               in_acc;
    logic               byte_push;
    logic               block_full;
    logic               pad_push;
    logic               comp;
    logic               shift;
    logic               out_done;

    // request handshake and byte placement
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign pos        = r_cnt[5:0];
    assign byte_push  = in_acc && i_in_req.byte_present && (pos[1:0] == 2'd3);
    assign block_full = in_acc && i_in_req.byte_present && (pos == 6'd63);
    assign byte_word  = {r_acc, i_in_req.msg_byte};
    assign pad_push   = (r_state == S_PAD);
    assign comp       = (r_state == S_COMP);
    assign out_done   = (r_state == S_OUT) && !i_out_stall && (r_oidx == 3'd4);

    // first padding word: leftover bytes, then the marker byte, then zeros
    always_comb begin
        case (pos[1:0])
            2'd0:    first_word = {sha1md_pkg::PAD_BYTE, 24'h0};
            2'd1:    first_word = {r_acc[7:0], sha1md_pkg::PAD_BYTE, 16'h0};
            2'd2:    first_word = {r_acc[15:0], sha1md_pkg::PAD_BYTE, 8'h0};
            default: first_word = {r_acc[23:0], sha1md_pkg::PAD_BYTE};
        endcase
    end

    // padding word stream: marker word, zeros, 64-bit bit length
    always_comb begin
        if (r_first) begin
            pad_word = first_word;
        end else if (r_len_here && (r_wi == 4'd14)) begin
            pad_word = r_cnt[60:29];
        end else if (r_len_here && (r_wi == 4'd15)) begin
            pad_word = {r_cnt[28:0], 3'b000};
        end else begin
            pad_word = '0;
        end
    end

    // schedule expansion from the chain taps
    assign xor_w     = w_cell[13] ^ w_cell[8] ^ w_cell[2] ^ w_cell[0];
    assign sched_new = {xor_w[30:0], xor_w[31]};

    always_comb begin
        if (comp) begin
            tail_in = sched_new;
        end else if (pad_push) begin
            tail_in = pad_word;
        end else begin
            tail_in = byte_word;
        end
    end

    assign shift = byte_push || pad_push || comp;

    // chain of schedule cells, oldest word in cell 0
    for (genvar g = 0; g < sha1md_pkg::BLOCK_WORDS; g++) begin : g_cell
        if (g == sha1md_pkg::BLOCK_WORDS - 1) begin : g_tail
            sha1md_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_word  (tail_in),
                .o_word  (w_cell[g])
            );
        end else begin : g_body
            sha1md_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_word  (w_cell[g+1]),
                .o_word  (w_cell[g])
            );
        end
    end

    // round unit control
    always_comb begin
        ctl.init = out_done;
        ctl.load = block_full || (pad_push && (r_wi == 4'd15));
        ctl.step = comp;
        ctl.fold = (r_state == S_ADD);
    end

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_round (r_t),
        .i_w     (w_cell[0]),
        .o_h     (h)
    );

    // partial word of bytes not yet pushed
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.byte_present) begin
            r_acc <= {r_acc[15:0], i_in_req.msg_byte};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_t           <= '0;
            r_wi          <= '0;
            r_oidx        <= '0;
            r_fin         <= 1'b0;
            r_first       <= 1'b0;
            r_len_here    <= 1'b0;
            r_len_sent    <= 1'b0;
            r_pad_started <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_req.byte_present) begin
                            r_cnt <= r_cnt + 61'd1;
                        end
                        if (block_full) begin
                            r_state <= S_COMP;
                            r_t     <= '0;
                            r_fin   <= i_in_req.end_of_message;
                        end else if (i_in_req.end_of_message) begin
                            r_state <= S_PSET;
                            r_fin   <= 1'b1;
                        end
                    end
                end
                S_COMP: begin
                    r_t <= r_t + 7'd1;
                    if (r_t == 7'(sha1md_pkg::ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_len_sent) begin
                        r_state <= S_OUT;
                        r_oidx  <= '0;
                    end else if (r_pad_started) begin
                        r_state    <= S_PAD;
                        r_wi       <= '0;
                        r_first    <= 1'b0;
                        r_len_here <= 1'b1;
                    end else begin
                        r_state <= S_PSET;
                    end
                end
                S_PSET: begin
                    r_state       <= S_PAD;
                    r_wi          <= pos[5:2];
                    r_first       <= 1'b1;
                    r_len_here    <= (pos[5:3] != 3'b111);
                    r_pad_started <= 1'b1;
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    r_wi    <= r_wi + 4'd1;
                    if (r_wi == 4'd15) begin
                        r_state <= S_COMP;
                        r_t     <= '0;
                        if (r_len_here) begin
                            r_len_sent <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (r_oidx == 3'd4) begin
                            r_state       <= S_IDLE;
                            r_cnt         <= '0;
                            r_fin         <= 1'b0;
                            r_len_sent    <= 1'b0;
                            r_pad_started <= 1'b0;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // digest output
    assign o_out_valid           = (r_state == S_OUT);
    assign o_out_req.digest_word = h[r_oidx];
    assign o_out_req.word_index  = r_oidx;
    assign o_out_req.last_word   = (r_oidx == 3'd4);

    // each taken byte advances the byte count by exactly one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_req.byte_present)
            |=> (r_cnt == $past(r_cnt) + 61'd1))
        else $error("byte count did not advance on a taken byte");

    // round counter stays inside the compression
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_t < 7'd80))
        else $error("round counter out of range");

    // after the last digest word the unit is cleared and ready
    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_req.last_word)
            |=> ((r_cnt == '0) && !o_in_stall && !r_len_sent))
        else $error("unit not cleared after digest");

endmodule

// ===== hw/rtl/sha1md_cell.sv =====
// sha1md_cell: one 32-bit cell of the message schedule chain
// depends on sha1md_pkg
module sha1md_cell (
    input  logic              i_clk,
    input  logic              i_shift,
    input  sha1md_pkg::t_word i_word,
    output sha1md_pkg::t_word o_word
);

    sha1md_pkg::t_word r_word;

    // take the neighbor's word on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== hw/rtl/sha1md_round.sv =====
// sha1md_round: working variables a..e, one sha-1 round per cycle, and the chaining value
// depends on sha1md_pkg
module sha1md_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1md_pkg::t_rnd_ctl i_ctl,
    input  logic [6:0]           i_round,
    input  sha1md_pkg::t_word    i_w,
    output sha1md_pkg::t_chain   o_h
);

    sha1md_pkg::t_chain r_h;
    sha1md_pkg::t_chain r_v;   // [0]=a .. [4]=e
    sha1md_pkg::t_word  n_a;

    // new a for this round
    always_comb begin
        n_a = {r_v[0][26:0], r_v[0][31:27]}
            + sha1md_pkg::round_f(i_round, r_v[1], r_v[2], r_v[3])
            + r_v[4] + sha1md_pkg::round_k(i_round) + i_w;
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= sha1md_pkg::INIT_CHAIN;
        end else if (i_ctl.init) begin
            r_h <= sha1md_pkg::INIT_CHAIN;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= r_h;
        end else if (i_ctl.step) begin
            r_v[4] <= r_v[3];
            r_v[3] <= r_v[2];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[1] <= r_v[0];
            r_v[0] <= n_a;
        end
    end

    assign o_h = r_h;

endmodule
